// ===== hdl/ilff_pkg.sv =====
// Package for the first-fit heap allocator: microcode word and status types,
// step numbers and the microcode program ROM. No dependencies.
package ilff_pkg;

	localparam int ADDR_W = 12;
	localparam int REQ_W  = 13;
	localparam int STEP_W = 5;

	typedef enum logic [2:0] {
		WA_PAD,
		WA_PRO_HDR,
		WA_PRO_FTR,
		WA_EPI,
		WA_OFF,
		WA_NEED_FTR,
		WA_NEED_END,
		WA_SIZE_FTR
	} wa_sel_t;

	typedef enum logic [2:0] {
		WD_ZERO,
		WD_PROLOGUE,
		WD_EPI,
		WD_NEED_USED,
		WD_SIZE_USED,
		WD_SIZE
	} wd_sel_t;

	typedef enum logic [1:0] {
		EM_NONE,
		EM_OK,
		EM_FAIL,
		EM_ECHO
	} emit_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_FREE,
		C_REQ_ZERO,
		C_OFF_BAD,
		C_EPI,
		C_ZERO_TAG,
		C_FIT,
		C_NO_ROOM,
		C_HDR_BAD,
		C_FOOT_NEG
	} cond_t;

	localparam logic [STEP_W-1:0] S_INIT0     = 5'd0;
	localparam logic [STEP_W-1:0] S_INIT1     = 5'd1;
	localparam logic [STEP_W-1:0] S_INIT2     = 5'd2;
	localparam logic [STEP_W-1:0] S_INIT3     = 5'd3;
	localparam logic [STEP_W-1:0] S_IDLE      = 5'd4;
	localparam logic [STEP_W-1:0] S_DISP      = 5'd5;
	localparam logic [STEP_W-1:0] S_ZCHK      = 5'd6;
	localparam logic [STEP_W-1:0] S_WALK      = 5'd7;
	localparam logic [STEP_W-1:0] S_TAG_EPI   = 5'd8;
	localparam logic [STEP_W-1:0] S_TAG_ZERO  = 5'd9;
	localparam logic [STEP_W-1:0] S_TAG_FIT   = 5'd10;
	localparam logic [STEP_W-1:0] S_ADV       = 5'd11;
	localparam logic [STEP_W-1:0] S_APPEND    = 5'd12;
	localparam logic [STEP_W-1:0] S_APP_HDR   = 5'd13;
	localparam logic [STEP_W-1:0] S_APP_FTR   = 5'd14;
	localparam logic [STEP_W-1:0] S_APP_EPI   = 5'd15;
	localparam logic [STEP_W-1:0] S_MARK_HDR  = 5'd16;
	localparam logic [STEP_W-1:0] S_MARK_FTR  = 5'd17;
	localparam logic [STEP_W-1:0] S_DONE_OK   = 5'd18;
	localparam logic [STEP_W-1:0] S_FAIL      = 5'd19;
	localparam logic [STEP_W-1:0] S_FREE_RD   = 5'd20;
	localparam logic [STEP_W-1:0] S_FREE_HDR  = 5'd21;
	localparam logic [STEP_W-1:0] S_FREE_CHK  = 5'd22;
	localparam logic [STEP_W-1:0] S_FREE_FTR  = 5'd23;
	localparam logic [STEP_W-1:0] S_DONE_FREE = 5'd24;

	typedef struct packed {
		logic              take;
		logic              rd;
		logic              wr;
		wa_sel_t           wa;
		wd_sel_t           wd;
		logic              adv;
		emit_t             emit;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic is_free;
		logic req_zero;
		logic off_bad;
		logic epi;
		logic zero_tag;
		logic fit;
		logic no_room;
		logic hdr_bad;
		logic foot_neg;
		logic out_busy;
	} stat_t;

	localparam ctrl_t CTRL_NOP = '{
		take: 1'b0, rd: 1'b0, wr: 1'b0, wa: WA_PAD, wd: WD_ZERO,
		adv: 1'b0, emit: EM_NONE, cond: C_NEVER, target: S_INIT0
	};

	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = CTRL_NOP;
		unique case (step)
			S_INIT0: begin
				c.wr = 1'b1; c.wa = WA_PAD; c.wd = WD_ZERO;
			end
			S_INIT1: begin
				c.wr = 1'b1; c.wa = WA_PRO_HDR; c.wd = WD_PROLOGUE;
			end
			S_INIT2: begin
				c.wr = 1'b1; c.wa = WA_PRO_FTR; c.wd = WD_PROLOGUE;
			end
			S_INIT3: begin
				c.wr = 1'b1; c.wa = WA_EPI; c.wd = WD_EPI;
			end
			S_IDLE: begin
				c.take = 1'b1; c.cond = C_NO_REQ; c.target = S_IDLE;
			end
			S_DISP: begin
				c.cond = C_FREE; c.target = S_FREE_RD;
			end
			S_ZCHK: begin
				c.cond = C_REQ_ZERO; c.target = S_FAIL;
			end
			S_WALK: begin
				c.rd = 1'b1; c.cond = C_OFF_BAD; c.target = S_FAIL;
			end
			S_TAG_EPI: begin
				c.cond = C_EPI; c.target = S_APPEND;
			end
			S_TAG_ZERO: begin
				c.cond = C_ZERO_TAG; c.target = S_FAIL;
			end
			S_TAG_FIT: begin
				c.cond = C_FIT; c.target = S_MARK_HDR;
			end
			S_ADV: begin
				c.adv = 1'b1; c.cond = C_ALWAYS; c.target = S_WALK;
			end
			S_APPEND: begin
				c.cond = C_NO_ROOM; c.target = S_FAIL;
			end
			S_APP_HDR: begin
				c.wr = 1'b1; c.wa = WA_OFF; c.wd = WD_NEED_USED;
			end
			S_APP_FTR: begin
				c.wr = 1'b1; c.wa = WA_NEED_FTR; c.wd = WD_NEED_USED;
			end
			S_APP_EPI: begin
				c.wr = 1'b1; c.wa = WA_NEED_END; c.wd = WD_EPI;
				c.cond = C_ALWAYS; c.target = S_DONE_OK;
			end
			S_MARK_HDR: begin
				c.wr = 1'b1; c.wa = WA_OFF; c.wd = WD_SIZE_USED;
			end
			S_MARK_FTR: begin
				c.wr = 1'b1; c.wa = WA_SIZE_FTR; c.wd = WD_SIZE_USED;
			end
			S_DONE_OK: begin
				c.emit = EM_OK; c.cond = C_ALWAYS; c.target = S_IDLE;
			end
			S_FAIL: begin
				c.emit = EM_FAIL; c.cond = C_ALWAYS; c.target = S_IDLE;
			end
			S_FREE_RD: begin
				c.rd = 1'b1; c.cond = C_HDR_BAD; c.target = S_DONE_FREE;
			end
			S_FREE_HDR: begin
				c.wr = 1'b1; c.wa = WA_OFF; c.wd = WD_SIZE;
			end
			S_FREE_CHK: begin
				c.cond = C_FOOT_NEG; c.target = S_DONE_FREE;
			end
			S_FREE_FTR: begin
				c.wr = 1'b1; c.wa = WA_SIZE_FTR; c.wd = WD_SIZE;
			end
			S_DONE_FREE: begin
				c.emit = EM_ECHO; c.cond = C_ALWAYS; c.target = S_IDLE;
			end
			default: begin
				c.cond = C_ALWAYS; c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/ilff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ilff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/ilff_seq.sv =====
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on ilff_pkg.
module ilff_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  ilff_pkg::stat_t stat,
	output ilff_pkg::ctrl_t ctrl
);
	import ilff_pkg::*;

	logic [STEP_W-1:0] upc_q;
	logic              hit;
	logic              stall;

	assign ctrl = ucode(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:    hit = 1'b0;
			C_ALWAYS:   hit = 1'b1;
			C_NO_REQ:   hit = !stat.in_valid;
			C_FREE:     hit = stat.is_free;
			C_REQ_ZERO: hit = stat.req_zero;
			C_OFF_BAD:  hit = stat.off_bad;
			C_EPI:      hit = stat.epi;
			C_ZERO_TAG: hit = stat.zero_tag;
			C_FIT:      hit = stat.fit;
			C_NO_ROOM:  hit = stat.no_room;
			C_HDR_BAD:  hit = stat.hdr_bad;
			C_FOOT_NEG: hit = stat.foot_neg;
			default:    hit = 1'b0;
		endcase
	end

	// result steps wait while the output register still holds an untaken result
	assign stall = (ctrl.emit != EM_NONE) && stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_INIT0;
		end else if (!stall) begin
			upc_q <= hit ? ctrl.target : upc_q + STEP_W'(1);
		end
	end

endmodule

// ===== hdl/ilff_dp.sv =====
// Allocator datapath: request registers, walk offset, tag store, condition
// flags and the output register. Depends on ilff_pkg and ilff_ram.
module ilff_dp #(
	parameter int HEAP_BYTES   = 4096,
	parameter int UNIT_BYTES   = 8,
	parameter int HEADER_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ilff_pkg::ctrl_t              ctrl,
	output ilff_pkg::stat_t              stat,
	input  logic                         in_valid,
	input  logic                         kind,
	input  logic [ilff_pkg::REQ_W-1:0]   request_bytes,
	input  logic [ilff_pkg::ADDR_W-1:0]  free_address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ilff_pkg::ADDR_W-1:0]  payload_address,
	output logic                         failed
);
	import ilff_pkg::*;

	localparam int LOG_HEAP = $clog2(HEAP_BYTES);
	localparam int TW       = LOG_HEAP + 1;
	localparam int OW       = ((LOG_HEAP > 14) ? LOG_HEAP : 14) + 2;
	localparam int GRAIN    = (UNIT_BYTES < HEADER_BYTES) ? UNIT_BYTES : HEADER_BYTES;
	localparam int LG       = $clog2(GRAIN);
	localparam int DEPTH    = HEAP_BYTES / GRAIN;
	localparam int SW       = $clog2(DEPTH);
	localparam int SPAN     = DEPTH * GRAIN;

	localparam logic [OW-1:0] HDR_O   = OW'(HEADER_BYTES);
	localparam logic [OW-1:0] TWO_H   = OW'(2 * HEADER_BYTES);
	localparam logic [OW-1:0] THREE_H = OW'(3 * HEADER_BYTES);
	localparam logic [OW-1:0] HEAP_O  = OW'(HEAP_BYTES);
	localparam logic [OW-1:0] SPAN_O  = OW'(SPAN);
	localparam logic [OW-1:0] ROUND_O = OW'(UNIT_BYTES - 1);
	localparam logic [TW-1:0] USED_T  = TW'(1);
	localparam logic [TW-1:0] PRO_T   = TW'(2 * HEADER_BYTES) | USED_T;

	function automatic logic slot_ok(input logic [OW-1:0] o);
		return (o[LG-1:0] == '0) && (o < SPAN_O);
	endfunction

	logic [OW-1:0]     off_q;
	logic [OW-1:0]     need_q;
	logic [ADDR_W-1:0] addr_q;
	logic              kind_q;
	logic              req_zero_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] payload_q;
	logic              failed_q;

	logic              take;
	logic [OW-1:0]     need_raw;
	logic [OW-1:0]     need_new;
	logic [TW-1:0]     rd_tag;
	logic [OW-1:0]     tag_size;
	logic              tag_used;
	logic [OW-1:0]     wr_off;
	logic [TW-1:0]     wr_tag;
	logic              we;
	logic [OW-1:0]     off_plus_h;
	logic              out_busy;
	logic              emit_go;

	assign take     = in_valid && ctrl.take;
	assign need_raw = OW'(request_bytes) + TWO_H + ROUND_O;
	assign need_new = need_raw & ~ROUND_O;

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q     <= kind;
			req_zero_q <= (request_bytes == '0);
			need_q     <= need_new;
			addr_q     <= free_address;
			off_q      <= kind ? (OW'(free_address) - HDR_O) : THREE_H;
		end else if (ctrl.adv) begin
			off_q <= off_q + tag_size;
		end
	end

	assign tag_size = OW'({rd_tag[TW-1:2], 2'b00});
	assign tag_used = rd_tag[0];

	always_comb begin
		unique case (ctrl.wa)
			WA_PAD:      wr_off = '0;
			WA_PRO_HDR:  wr_off = HDR_O;
			WA_PRO_FTR:  wr_off = TWO_H;
			WA_EPI:      wr_off = THREE_H;
			WA_OFF:      wr_off = off_q;
			WA_NEED_FTR: wr_off = off_q + need_q - HDR_O;
			WA_NEED_END: wr_off = off_q + need_q;
			WA_SIZE_FTR: wr_off = off_q + tag_size - HDR_O;
			default:     wr_off = '0;
		endcase
	end

	always_comb begin
		unique case (ctrl.wd)
			WD_ZERO:      wr_tag = '0;
			WD_PROLOGUE:  wr_tag = PRO_T;
			WD_EPI:       wr_tag = USED_T;
			WD_NEED_USED: wr_tag = need_q[TW-1:0] | USED_T;
			WD_SIZE_USED: wr_tag = tag_size[TW-1:0] | USED_T;
			WD_SIZE:      wr_tag = tag_size[TW-1:0];
			default:      wr_tag = '0;
		endcase
	end

	assign we = ctrl.wr && slot_ok(wr_off);

	ilff_ram #(
		.WIDTH(TW),
		.DEPTH(DEPTH)
	) u_tags (
		.clk  (clk),
		.we   (we),
		.waddr(wr_off[LG +: SW]),
		.wdata(wr_tag),
		.re   (ctrl.rd),
		.raddr(off_q[LG +: SW]),
		.rdata(rd_tag)
	);

	assign out_busy = out_valid_q && !out_ready;
	assign emit_go  = (ctrl.emit != EM_NONE) && !out_busy;

	assign stat.in_valid = in_valid;
	assign stat.is_free  = kind_q;
	assign stat.req_zero = req_zero_q;
	assign stat.off_bad  = !slot_ok(off_q);
	assign stat.epi      = (tag_size == '0) && tag_used;
	assign stat.zero_tag = (tag_size == '0) && !tag_used;
	assign stat.fit      = !tag_used && (tag_size >= need_q);
	assign stat.no_room  = (off_q + need_q + HDR_O) > HEAP_O;
	assign stat.hdr_bad  = (OW'(addr_q) < HDR_O) || !slot_ok(off_q);
	assign stat.foot_neg = (off_q + tag_size) < HDR_O;
	assign stat.out_busy = out_busy;

	assign off_plus_h = off_q + HDR_O;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			unique case (ctrl.emit)
				EM_OK: begin
					payload_q <= off_plus_h[ADDR_W-1:0];
					failed_q  <= 1'b0;
				end
				EM_FAIL: begin
					payload_q <= '0;
					failed_q  <= 1'b1;
				end
				EM_ECHO: begin
					payload_q <= addr_q;
					failed_q  <= 1'b0;
				end
				default: begin
					payload_q <= payload_q;
					failed_q  <= failed_q;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign payload_address = payload_q;
	assign failed          = failed_q;

endmodule

// ===== hdl/implicit_list_first_fit_alloc_unit.sv =====
// First-fit allocator over an implicit block list held in a tag RAM with one
// tag per slot (min of unit and header size). After reset the sequencer writes
// the pad, prologue and epilogue tags before it takes the first request. One
// request is worked at a time, paced by the microcode and the single read port
// of the tag RAM. An allocate walks the block headers one by one from the first
// block until it marks a free block that fits as used or appends a new block
// at the epilogue; a zero-byte allocate fails without a walk, and a free clears
// the used bit in the block's header and then in its footer.
// A result step waits for as long as the output register still holds an
// untaken result.
// The result sits in an output register, so the next request is taken while
// it waits; blocks are never split or coalesced and the heap never grows.
// Depends on ilff_pkg, ilff_seq and ilff_dp.
module implicit_list_first_fit_alloc_unit #(
	parameter int HEAP_BYTES   = 4096,
	parameter int UNIT_BYTES   = 8,
	parameter int HEADER_BYTES = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [ilff_pkg::REQ_W-1:0]   request_bytes,
	input  logic [ilff_pkg::ADDR_W-1:0]  free_address,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ilff_pkg::ADDR_W-1:0]  payload_address,
	output logic                         failed
);
	import ilff_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	ilff_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl)
	);

	ilff_dp #(
		.HEAP_BYTES  (HEAP_BYTES),
		.UNIT_BYTES  (UNIT_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.in_valid       (in_valid),
		.kind           (kind),
		.request_bytes  (request_bytes),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.payload_address(payload_address),
		.failed         (failed)
	);

	assign in_ready = ctrl.take;

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> payload_address == '0)
		else $error("failed result carries nonzero address");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in progress");

	a_result_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit != EM_NONE) && stat.out_busy |=> $stable(ctrl))
		else $error("sequencer left a result step while output was busy");

endmodule
